[hdl/kth_pkg.sv]
`timescale 1ns / 1ps
package kth_pkg;

    localparam int CP_W = 21;

    typedef logic [CP_W-1:0] cp_t;

    // Vowel codes of the kana table.
    typedef logic [2:0] vowel_t;
    localparam vowel_t VOW_NONE = 3'd0;
    localparam vowel_t VOW_A    = 3'd1;
    localparam vowel_t VOW_I    = 3'd2;
    localparam vowel_t VOW_U    = 3'd3;
    localparam vowel_t VOW_E    = 3'd4;
    localparam vowel_t VOW_O    = 3'd5;

    localparam cp_t SMALL_KA        = 21'h030F5;
    localparam cp_t SMALL_KE        = 21'h030F6;
    localparam cp_t PROLONGED_MARK  = 21'h030FC;
    localparam cp_t HIRA_FIRST      = 21'h03041;
    localparam cp_t HIRA_LAST       = 21'h03096;
    localparam cp_t KATA_FIRST      = 21'h030A1;
    localparam cp_t KATA_SHIFT_LAST = 21'h030F4;
    localparam cp_t KATA_TAIL_LAST  = 21'h030FA;
    localparam cp_t KATA_OFFSET     = KATA_FIRST - HIRA_FIRST;

    localparam cp_t KANA_A = 21'h03042;
    localparam cp_t KANA_I = 21'h03044;
    localparam cp_t KANA_U = 21'h03046;
    localparam cp_t KANA_E = 21'h03048;

    localparam int HIRA_N = 86;
    localparam int TAIL_N = 7;

    // Vowel of each hiragana from U+3041 on.
    localparam vowel_t HIRA_VOWEL [HIRA_N] = '{
        VOW_A, VOW_A, VOW_I, VOW_I, VOW_U, VOW_U, VOW_E, VOW_E, VOW_O, VOW_O,
        VOW_A, VOW_A, VOW_I, VOW_I, VOW_U, VOW_U, VOW_E, VOW_E, VOW_O, VOW_O,
        VOW_A, VOW_A, VOW_I, VOW_I, VOW_U, VOW_U, VOW_E, VOW_E, VOW_O, VOW_O,
        VOW_A, VOW_A, VOW_I, VOW_I, VOW_U, VOW_U, VOW_U, VOW_E, VOW_E, VOW_O,
        VOW_O,
        VOW_A, VOW_I, VOW_U, VOW_E, VOW_O,
        VOW_A, VOW_A, VOW_A, VOW_I, VOW_I, VOW_I, VOW_U, VOW_U, VOW_U, VOW_E,
        VOW_E, VOW_E, VOW_O, VOW_O, VOW_O,
        VOW_A, VOW_I, VOW_U, VOW_E, VOW_O,
        VOW_A, VOW_A, VOW_U, VOW_U, VOW_O, VOW_O,
        VOW_A, VOW_I, VOW_U, VOW_E, VOW_O,
        VOW_A, VOW_A, VOW_I, VOW_E, VOW_O, VOW_NONE, VOW_NONE, VOW_NONE,
        VOW_NONE
    };

    // Vowels of the katakana tail U+30F4 to U+30FA.
    localparam vowel_t TAIL_VOWEL [TAIL_N] = '{
        VOW_U, VOW_A, VOW_E, VOW_A, VOW_I, VOW_E, VOW_O
    };

    // History carried from one item to the next.
    typedef struct packed {
        logic   valid;
        vowel_t vowel;
    } hist_t;

    function automatic vowel_t vowel_of(input cp_t c);
        cp_t    h;
        cp_t    diff;
        vowel_t v;
        h = c;
        v = VOW_NONE;
        if (c >= KATA_FIRST && c < KATA_SHIFT_LAST)
        begin
            h = c - KATA_OFFSET;
        end
        if (c >= KATA_SHIFT_LAST && c <= KATA_TAIL_LAST)
        begin
            diff = c - KATA_SHIFT_LAST;
            v = TAIL_VOWEL[diff[2:0]];
        end
        else if (h >= HIRA_FIRST && h <= HIRA_LAST)
        begin
            diff = h - HIRA_FIRST;
            v = HIRA_VOWEL[diff[6:0]];
        end
        return v;
    endfunction

endpackage

[hdl/kth_in_if.sv]
`timescale 1ns / 1ps
interface kth_in_if;
    logic             valid;
    logic             ready;
    kth_pkg::cp_t     code_point;
    logic             start_of_text;

    modport source (output valid, output code_point, output start_of_text, input ready);
    modport sink (input valid, input code_point, input start_of_text, output ready);
endinterface

[hdl/kth_out_if.sv]
`timescale 1ns / 1ps
interface kth_out_if;
    logic             valid;
    logic             ready;
    kth_pkg::cp_t     converted_point;

    modport source (output valid, output converted_point, input ready);
    modport sink (input valid, input converted_point, output ready);
endinterface

[hdl/kth_conv.sv]
`timescale 1ns / 1ps
module kth_conv (
    input  kth_pkg::cp_t    code_point,
    input  logic            start_of_text,
    input  kth_pkg::hist_t  hist,
    output kth_pkg::cp_t    result,
    output kth_pkg::vowel_t result_vowel
);

    logic         hist_ok;
    kth_pkg::cp_t mark_kana;

    assign hist_ok = hist.valid && !start_of_text;

    always_comb
    begin
        mark_kana = code_point;
        case (hist.vowel)
            kth_pkg::VOW_A: mark_kana = kth_pkg::KANA_A;
            kth_pkg::VOW_I: mark_kana = kth_pkg::KANA_I;
            kth_pkg::VOW_U: mark_kana = kth_pkg::KANA_U;
            kth_pkg::VOW_E: mark_kana = kth_pkg::KANA_E;
            kth_pkg::VOW_O: mark_kana = kth_pkg::KANA_U;
            default:        mark_kana = code_point;
        endcase
    end

    always_comb
    begin
        result = code_point;
        if (code_point == kth_pkg::SMALL_KA || code_point == kth_pkg::SMALL_KE)
        begin
            result = code_point;
        end
        else if (code_point == kth_pkg::PROLONGED_MARK)
        begin
            if (hist_ok)
            begin
                result = mark_kana;
            end
        end
        else if (code_point >= kth_pkg::KATA_FIRST && code_point <= kth_pkg::KATA_SHIFT_LAST)
        begin
            result = code_point - kth_pkg::KATA_OFFSET;
        end
    end

    // Only the vowel of the result is kept as history.
    assign result_vowel = kth_pkg::vowel_of(result);

endmodule

[hdl/katakana_to_hiragana_stream_top.sv]
`timescale 1ns / 1ps
// Converts a stream of code points from katakana to hiragana, one request per
// clock cycle sustained while out.ready holds. The result is presented once its
// request has passed the input register and the result register.
// The throughput is set by the one-character history loop: the vowel of each
// result is written back into a history register in the same cycle the item
// moves from the input register into the result register, so the next item
// sees it at once. A set start_of_text flag makes its item ignore that history.
module katakana_to_hiragana_stream_top (
    input  logic      clk,
    input  logic      rst_n,
    kth_in_if.sink    in,
    kth_out_if.source out
);

    logic            in_valid_reg;
    kth_pkg::cp_t    in_cp_reg;
    logic            in_sot_reg;
    logic            out_valid_reg;
    kth_pkg::cp_t    out_cp_reg;
    kth_pkg::hist_t  hist_reg;
    kth_pkg::hist_t  hist_next;
    logic            adv;
    kth_pkg::cp_t    result;
    kth_pkg::vowel_t result_vowel;

    assign adv      = in_valid_reg && (!out_valid_reg || out.ready);
    assign in.ready = !in_valid_reg || adv;

    kth_conv u_conv (
        .code_point    (in_cp_reg),
        .start_of_text (in_sot_reg),
        .hist          (hist_reg),
        .result        (result),
        .result_vowel  (result_vowel)
    );

    always_comb
    begin
        hist_next = hist_reg;
        if (adv)
        begin
            hist_next.valid = 1'b1;
            hist_next.vowel = result_vowel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_reg      <= '0;
        end
        else
        begin
            if (in.ready)
            begin
                in_valid_reg <= in.valid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            hist_reg <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in.valid && in.ready)
        begin
            in_cp_reg  <= in.code_point;
            in_sot_reg <= in.start_of_text;
        end
        if (adv)
        begin
            out_cp_reg <= result;
        end
    end

    assign out.valid           = out_valid_reg;
    assign out.converted_point = out_cp_reg;

    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("advanced request did not reach the result register");

    a_adv_sets_hist: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> hist_reg.valid)
        else $error("history not marked valid after a request");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !adv |=> in_valid_reg && $stable(in_cp_reg))
        else $error("stalled input request was lost or changed");

endmodule

[bench/kth_stream_checker.sv]
`timescale 1ns / 1ps
module kth_stream_checker (
    input  logic clk,
    input  logic rst_n,
    kth_in_if    in,
    kth_out_if   out,
    output int   errors,
    output int   pending
);

    kth_pkg::cp_t expected_points [$];
    kth_pkg::cp_t last_point;
    logic         have_last;

    // The vowel comes from the position in the gojuon-ordered hiragana block.
    function automatic kth_pkg::vowel_t kana_vowel(input kth_pkg::cp_t c);
        int idx;
        int grp;
        if (c >= kth_pkg::KATA_FIRST && c < kth_pkg::KATA_SHIFT_LAST)
        begin
            c = c - kth_pkg::KATA_OFFSET;
        end
        else if (c >= kth_pkg::KATA_SHIFT_LAST && c <= kth_pkg::KATA_TAIL_LAST)
        begin
            case (c - kth_pkg::KATA_SHIFT_LAST)
                0: return kth_pkg::VOW_U;
                1: return kth_pkg::VOW_A;
                2: return kth_pkg::VOW_E;
                3: return kth_pkg::VOW_A;
                4: return kth_pkg::VOW_I;
                5: return kth_pkg::VOW_E;
                default: return kth_pkg::VOW_O;
            endcase
        end
        if (c < kth_pkg::HIRA_FIRST || c > kth_pkg::HIRA_LAST)
        begin
            return kth_pkg::VOW_NONE;
        end
        idx = int'(c - kth_pkg::HIRA_FIRST);
        if (idx < 30)
        begin
            return kth_pkg::vowel_t'(kth_pkg::VOW_A + (idx / 2) % 5);
        end
        else if (idx < 41)
        begin
            // The t row carries the small tsu, so u takes three places.
            grp = idx - 30;
            if (grp < 2)
                return kth_pkg::VOW_A;
            else if (grp < 4)
                return kth_pkg::VOW_I;
            else if (grp < 7)
                return kth_pkg::VOW_U;
            else if (grp < 9)
                return kth_pkg::VOW_E;
            else
                return kth_pkg::VOW_O;
        end
        else if (idx < 46)
        begin
            return kth_pkg::vowel_t'(kth_pkg::VOW_A + (idx - 41));
        end
        else if (idx < 61)
        begin
            return kth_pkg::vowel_t'(kth_pkg::VOW_A + (idx - 46) / 3);
        end
        else if (idx < 66)
        begin
            return kth_pkg::vowel_t'(kth_pkg::VOW_A + (idx - 61));
        end
        else if (idx < 72)
        begin
            grp = (idx - 66) / 2;
            if (grp == 0)
                return kth_pkg::VOW_A;
            else if (grp == 1)
                return kth_pkg::VOW_U;
            else
                return kth_pkg::VOW_O;
        end
        else if (idx < 77)
        begin
            return kth_pkg::vowel_t'(kth_pkg::VOW_A + (idx - 72));
        end
        else if (idx < 82)
        begin
            case (idx - 77)
                0, 1: return kth_pkg::VOW_A;
                2: return kth_pkg::VOW_I;
                3: return kth_pkg::VOW_E;
                default: return kth_pkg::VOW_O;
            endcase
        end
        return kth_pkg::VOW_NONE;
    endfunction

    // Works out the converted point of one request and moves the history on.
    function automatic kth_pkg::cp_t convert_point(input kth_pkg::cp_t c,
                                                   input logic new_text);
        kth_pkg::cp_t r;
        r = c;
        if (new_text)
        begin
            have_last = 1'b0;
        end
        if (c == kth_pkg::PROLONGED_MARK)
        begin
            if (have_last)
            begin
                case (kana_vowel(last_point)) inside
                    kth_pkg::VOW_A: r = kth_pkg::KANA_A;
                    kth_pkg::VOW_I: r = kth_pkg::KANA_I;
                    kth_pkg::VOW_U, kth_pkg::VOW_O: r = kth_pkg::KANA_U;
                    kth_pkg::VOW_E: r = kth_pkg::KANA_E;
                    default: r = c;
                endcase
            end
        end
        else if (c >= kth_pkg::KATA_FIRST && c <= kth_pkg::KATA_SHIFT_LAST)
        begin
            r = c - kth_pkg::KATA_OFFSET;
        end
        last_point = r;
        have_last = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kth_pkg::cp_t want;
        if (!rst_n)
        begin
            expected_points.delete();
            last_point = '0;
            have_last = 1'b0;
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (in.valid && in.ready)
            begin
                expected_points.push_back(convert_point(in.code_point, in.start_of_text));
            end
            if (out.valid && out.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("converted_point: none expected, actual %h", out.converted_point);
                    errors++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (out.converted_point !== want)
                    begin
                        $error("converted_point: expected %h, actual %h",
                               want, out.converted_point);
                        errors++;
                    end
                end
            end
            pending = expected_points.size();
        end
    end

endmodule

[bench/katakana_to_hiragana_stream_top_test.sv]
`timescale 1ns / 1ps
module katakana_to_hiragana_stream_top_test;

    typedef struct packed {
        logic         new_text;
        kth_pkg::cp_t point;
    } request_t;

    localparam int N_DIRECTED = 25;
    localparam int PHASE_ITEMS = 475;

    localparam request_t DIRECTED [N_DIRECTED] = '{
        '{1'b1, kth_pkg::PROLONGED_MARK},
        '{1'b0, 21'h000000},
        '{1'b0, 21'h1FFFFF},
        '{1'b0, 21'h10FFFF},
        '{1'b0, kth_pkg::PROLONGED_MARK},
        '{1'b0, kth_pkg::KATA_FIRST},
        '{1'b0, kth_pkg::PROLONGED_MARK},
        '{1'b0, 21'h0030AD},
        '{1'b0, kth_pkg::PROLONGED_MARK},
        '{1'b0, 21'h0030B9},
        '{1'b0, kth_pkg::PROLONGED_MARK},
        '{1'b0, 21'h0030C6},
        '{1'b0, kth_pkg::PROLONGED_MARK},
        '{1'b0, 21'h0030ED},
        '{1'b0, kth_pkg::PROLONGED_MARK},
        '{1'b0, 21'h0030F3},
        '{1'b0, kth_pkg::PROLONGED_MARK},
        '{1'b0, kth_pkg::KATA_SHIFT_LAST},
        '{1'b0, kth_pkg::SMALL_KA},
        '{1'b0, kth_pkg::PROLONGED_MARK},
        '{1'b0, kth_pkg::SMALL_KE},
        '{1'b0, kth_pkg::KATA_TAIL_LAST},
        '{1'b0, kth_pkg::PROLONGED_MARK},
        '{1'b1, 21'h0030F8},
        '{1'b1, kth_pkg::PROLONGED_MARK}
    };

    logic clk;
    logic rst_n;
    int   gap_pct;
    int   stall_pct;
    int   errors;
    int   pending;

    kth_in_if  points_in ();
    kth_out_if points_out ();

    katakana_to_hiragana_stream_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (points_in),
        .out   (points_out)
    );

    kth_stream_checker u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .in      (points_in),
        .out     (points_out),
        .errors  (errors),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        points_out.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Holds one request until it is taken, after a random idle gap.
    task automatic send_request(input request_t req);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            points_in.valid <= 1'b0;
            @(posedge clk);
        end
        points_in.valid <= 1'b1;
        points_in.code_point <= req.point;
        points_in.start_of_text <= req.new_text;
        @(posedge clk);
        while (!points_in.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Most points fall around the kana blocks so that prolonged marks meet
    // a real history; the rest spread over the whole field.
    function automatic request_t random_request();
        request_t req;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            req.point = kth_pkg::cp_t'($urandom_range(32'h3090, 32'h3100));
        else if (pick < 65)
            req.point = kth_pkg::PROLONGED_MARK;
        else if (pick < 80)
            req.point = kth_pkg::cp_t'($urandom_range(32'h3030, 32'h30A0));
        else if (pick < 90)
            req.point = kth_pkg::cp_t'($urandom_range(0, 32'h10FFFF));
        else
            req.point = kth_pkg::cp_t'($urandom());
        req.new_text = ($urandom_range(0, 9) == 0);
        return req;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        points_in.valid = 1'b0;
        points_in.code_point = '0;
        points_in.start_of_text = 1'b0;
        points_out.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_request(DIRECTED[i]);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 46; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 46; end
                default: begin gap_pct = 36; stall_pct = 36; end
            endcase
            repeat (PHASE_ITEMS)
            begin
                send_request(random_request());
            end
        end
        points_in.valid <= 1'b0;

        // The wait below lets the checker count the last accepted request before pending is polled.
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
